// ===== rtl/core/gmt_pkg.sv =====
// Shared types and constants for the group membership table with aging.
package gmt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int TIMEOUT_W = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

  localparam logic REG_IDX_TIMEOUT = 1'b0;

  localparam logic OP_JOIN = 1'b0;
  localparam logic OP_LEAVE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_LEFT = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_FULL = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_SWEEP,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic act;
    logic sweep;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic pass_done;
  } stat_t;

endpackage

// ===== rtl/core/gmt_regs.sv =====
// Configuration register file: timeout_seconds behind an APB-style port.
module gmt_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gmt_pkg::ADDR_W-1:0]         paddr,
  input  logic [gmt_pkg::DATA_W-1:0]         pwdata,
  output logic [gmt_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  output logic [gmt_pkg::TIMEOUT_W-1:0]      timeout_seconds
);

  logic wr_en;
  logic sel_timeout;

  assign pready = 1'b1;
  assign sel_timeout = (paddr[2] == gmt_pkg::REG_IDX_TIMEOUT);
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= gmt_pkg::TIMEOUT_RESET;
    end else if (wr_en && sel_timeout) begin
      timeout_seconds <= pwdata[gmt_pkg::TIMEOUT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_timeout) begin
      prdata = {{(gmt_pkg::DATA_W-gmt_pkg::TIMEOUT_W){1'b0}}, timeout_seconds};
    end
  end

endmodule

// ===== rtl/core/gmt_ctrl.sv =====
// Sequencer for one message: scan, act, sweep, flush.
module gmt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  gmt_pkg::stat_t  stat,
  output gmt_pkg::cmd_t   cmd,
  output logic            busy
);

  gmt_pkg::state_t state;
  gmt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gmt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      gmt_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = gmt_pkg::S_SCAN;
        end
      end
      gmt_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.pass_done) state_next = gmt_pkg::S_ACT;
      end
      gmt_pkg::S_ACT: begin
        cmd.act = 1'b1;
        state_next = gmt_pkg::S_SWEEP;
      end
      gmt_pkg::S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.pass_done) state_next = gmt_pkg::S_FLUSH;
      end
      gmt_pkg::S_FLUSH: begin
        cmd.flush = 1'b1;
        state_next = gmt_pkg::S_IDLE;
      end
      default: begin
        state_next = gmt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != gmt_pkg::S_IDLE);

`ifndef SYNTHESIS
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == gmt_pkg::S_SCAN)
    else $error("accepted message did not start a scan");

  a_done_in_pass: assert property (@(posedge clk) disable iff (rst)
    stat.pass_done |-> state == gmt_pkg::S_SCAN || state == gmt_pkg::S_SWEEP)
    else $error("pass end outside a scan or sweep");
`endif

endmodule

// ===== rtl/core/gmt_datapath.sv =====
// Table storage, slot walker, lookup, aging compare and result register.
module gmt_datapath #(
  parameter int TABLE_ENTRIES = gmt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gmt_pkg::cmd_t                     cmd,
  output gmt_pkg::stat_t                    stat,
  input  logic [gmt_pkg::TIMEOUT_W-1:0]     timeout_seconds,
  input  logic                              operation,
  input  logic [31:0]                       member_address,
  input  logic [31:0]                       current_time,
  output logic                              result_valid,
  output logic [1:0]                        event_kind,
  output logic [31:0]                       event_address,
  output logic                              last_event
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [31:0] mem_addr [TABLE_ENTRIES];
  logic [31:0] mem_time [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] valid;
  logic                     op_q;
  logic [31:0]              addr_q;
  logic [31:0]              now_q;
  logic [CNT_W-1:0]         cnt;
  logic [IDX_W-1:0]         rd_idx;
  logic                     stage_vld;
  logic [IDX_W-1:0]         idx_q;
  logic [31:0]              rd_addr_q;
  logic [31:0]              rd_time_q;
  logic                     hit_found;
  logic [IDX_W-1:0]         hit_idx;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;

  logic                     issue;
  logic                     is_join;
  logic                     act_add;
  logic                     act_full;
  logic                     act_ref;
  logic                     act_leave;
  logic                     mem_we;
  logic [IDX_W-1:0]         wr_idx;
  logic [31:0]              age;
  logic                     tmo;
  logic                     sc_hit;
  logic                     sc_free;
  logic                     ev_fire;
  gmt_pkg::event_kind_t     ev_kind;
  logic [31:0]              ev_addr;

  logic                     pend_vld;
  gmt_pkg::event_kind_t     pend_kind;
  logic [31:0]              pend_addr;
  logic                     out_fire;
  logic                     out_last;

  assign rd_idx = cnt[IDX_W-1:0];
  assign issue = (cmd.scan || cmd.sweep) && (cnt != LAST_CNT);
  assign stat.pass_done = stage_vld && (idx_q == LAST_IDX);

  assign is_join = (op_q == gmt_pkg::OP_JOIN);
  assign act_add = cmd.act && is_join && !hit_found && free_found;
  assign act_full = cmd.act && is_join && !hit_found && !free_found;
  assign act_ref = cmd.act && is_join && hit_found;
  assign act_leave = cmd.act && (op_q == gmt_pkg::OP_LEAVE) && hit_found;
  assign mem_we = act_add || act_ref;
  assign wr_idx = hit_found ? hit_idx : free_idx;

  assign age = now_q - rd_time_q;
  assign tmo = cmd.sweep && stage_vld && valid[idx_q] &&
               (age > {16'b0, timeout_seconds});
  assign sc_hit = cmd.scan && stage_vld && valid[idx_q] && !hit_found &&
                  (rd_addr_q == addr_q);
  assign sc_free = cmd.scan && stage_vld && !valid[idx_q] && !free_found;

  assign ev_fire = act_add || act_full || act_leave || tmo;
  assign ev_addr = tmo ? rd_addr_q : addr_q;

  always_comb begin
    ev_kind = gmt_pkg::KIND_TIMEOUT;
    if (act_add) ev_kind = gmt_pkg::KIND_ADDED;
    else if (act_full) ev_kind = gmt_pkg::KIND_FULL;
    else if (act_leave) ev_kind = gmt_pkg::KIND_LEFT;
  end

  // table memories: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_addr[wr_idx] <= addr_q;
      mem_time[wr_idx] <= now_q;
    end
    if (issue) begin
      rd_addr_q <= mem_addr[rd_idx];
      rd_time_q <= mem_time[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= operation;
      addr_q <= member_address;
      now_q <= current_time;
    end
    idx_q <= rd_idx;
    if (sc_hit) hit_idx <= idx_q;
    if (sc_free) free_idx <= idx_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      cnt <= '0;
      stage_vld <= 1'b0;
      hit_found <= 1'b0;
      free_found <= 1'b0;
    end else begin
      stage_vld <= issue;
      if (cmd.load || cmd.act) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.load) begin
        hit_found <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (sc_hit) hit_found <= 1'b1;
        if (sc_free) free_found <= 1'b1;
      end
      if (act_add) valid[free_idx] <= 1'b1;
      if (act_leave) valid[hit_idx] <= 1'b0;
      if (tmo) valid[idx_q] <= 1'b0;
    end
  end

  // one result is held back so the final beat can carry last_event
  assign out_fire = (ev_fire || cmd.flush) && pend_vld;
  assign out_last = !ev_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= out_fire;
      if (ev_fire) begin
        pend_vld <= 1'b1;
      end else if (cmd.flush) begin
        pend_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_fire) begin
      pend_kind <= ev_kind;
      pend_addr <= ev_addr;
    end
    if (out_fire) begin
      event_kind <= 2'(pend_kind);
      event_address <= pend_addr;
      last_event <= out_last;
    end
  end

`ifndef SYNTHESIS
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_event |=> !result_valid)
    else $error("result beat right after a final beat");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= LAST_CNT)
    else $error("slot counter beyond table");

  a_add_sets_valid: assert property (@(posedge clk) disable iff (rst)
    act_add |=> valid[$past(free_idx)])
    else $error("added member not marked valid");
`endif

endmodule

// ===== rtl/core/group_membership_table_aging_top.sv =====
// Top level of the group membership table with aging timeout.
// One message is taken when start is high and busy is low; busy then stays high while the
// message is worked on, so no new message is taken before it is through. Each message
// runs a lookup pass, an update step, an aging sweep and a flush step; the pass and the
// sweep walk the table memory, one slot per cycle through its single registered read port.
// Results come out as single-cycle beats on result_valid with no back-pressure, in order,
// one per cycle at most; the final beat of a message has last_event set, and a message
// with no event gives no beat.
// The final beat of a message lands in the cycle right after its busy window.
// timeout_seconds is at byte address 0 and should be written only while idle.
module group_membership_table_aging_top #(
  parameter int TABLE_ENTRIES = gmt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gmt_pkg::ADDR_W-1:0]  paddr,
  input  logic [gmt_pkg::DATA_W-1:0]  pwdata,
  output logic [gmt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation,
  input  logic [31:0]                 member_address,
  input  logic [31:0]                 current_time,
  output logic                        result_valid,
  output logic [1:0]                  event_kind,
  output logic [31:0]                 event_address,
  output logic                        last_event
);

  logic [gmt_pkg::TIMEOUT_W-1:0] timeout_seconds;
  gmt_pkg::cmd_t                 cmd;
  gmt_pkg::stat_t                stat;

  gmt_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .timeout_seconds (timeout_seconds)
  );

  gmt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  gmt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .timeout_seconds (timeout_seconds),
    .operation       (operation),
    .member_address  (member_address),
    .current_time    (current_time),
    .result_valid    (result_valid),
    .event_kind      (event_kind),
    .event_address   (event_address),
    .last_event      (last_event)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the group membership table with aging timeout.
module tb_top;

  localparam int ENTRIES = gmt_pkg::TABLE_ENTRIES_DEF;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_SIZE = 20;
  localparam logic [gmt_pkg::ADDR_W-1:0] TIMEOUT_PADDR = {gmt_pkg::REG_IDX_TIMEOUT, 2'b00};

  typedef struct packed {
    gmt_pkg::event_kind_t kind;
    logic [31:0] addr;
    logic        last;
  } member_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [gmt_pkg::ADDR_W-1:0] paddr = '0;
  logic [gmt_pkg::DATA_W-1:0] pwdata = '0;
  logic [gmt_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic operation = gmt_pkg::OP_JOIN;
  logic [31:0] member_address = '0;
  logic [31:0] current_time = '0;
  logic result_valid;
  logic [1:0] event_kind;
  logic [31:0] event_address;
  logic last_event;

  // mirror of the table
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_addr [ENTRIES];
  logic [31:0] tbl_active [ENTRIES];
  logic [15:0] timeout_cfg = gmt_pkg::TIMEOUT_RESET;

  member_event_t expected_events [$];
  logic [31:0] addr_pool [POOL_SIZE];
  int fail_count = 0;
  int stall_cycles = 0;

  group_membership_table_aging_top DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .operation(operation), .member_address(member_address), .current_time(current_time),
    .result_valid(result_valid), .event_kind(event_kind), .event_address(event_address),
    .last_event(last_event)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void predict_events(input logic op, input logic [31:0] addr,
                                         input logic [31:0] now);
    int hit;
    int free_slot;
    logic [31:0] age;
    member_event_t evs [$];
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        if (hit < 0 && tbl_addr[i] == addr) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (op == gmt_pkg::OP_JOIN) begin
      if (hit >= 0) begin
        tbl_active[hit] = now;
      end else if (free_slot >= 0) begin
        tbl_valid[free_slot] = 1'b1;
        tbl_addr[free_slot] = addr;
        tbl_active[free_slot] = now;
        evs.push_back('{gmt_pkg::KIND_ADDED, addr, 1'b0});
      end else begin
        evs.push_back('{gmt_pkg::KIND_FULL, addr, 1'b0});
      end
    end else if (hit >= 0) begin
      tbl_valid[hit] = 1'b0;
      evs.push_back('{gmt_pkg::KIND_LEFT, addr, 1'b0});
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        age = now - tbl_active[i];
        if (age > {16'b0, timeout_cfg}) begin
          tbl_valid[i] = 1'b0;
          evs.push_back('{gmt_pkg::KIND_TIMEOUT, tbl_addr[i], 1'b0});
        end
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) expected_events.push_back(evs[i]);
  endfunction

  task automatic send_msg(input logic op, input logic [31:0] addr, input logic [31:0] now);
    @(negedge clk);
    start <= 1'b1;
    operation <= op;
    member_address <= addr;
    current_time <= now;
    do @(posedge clk); while (busy);
    predict_events(op, addr, now);
  endtask

  task automatic idle_for(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    operation <= 1'($urandom);
    member_address <= $urandom;
    current_time <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_idle();
    idle_for(0);
    while (expected_events.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write through APB, then read back; upper bits are dropped by the register
  task automatic write_timeout(input logic [31:0] value);
    wait_idle();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TIMEOUT_PADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    timeout_cfg = value[15:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    pwdata <= $urandom;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'b0, timeout_cfg}) begin
      $error("prdata: expected %0h actual %0h", {16'b0, timeout_cfg}, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_join_leave();
    send_msg(gmt_pkg::OP_JOIN, 32'hC0A8_0001, 32'd100);
    send_msg(gmt_pkg::OP_JOIN, 32'hC0A8_0001, 32'd110);
    send_msg(gmt_pkg::OP_LEAVE, 32'hC0A8_0002, 32'd111);
    send_msg(gmt_pkg::OP_LEAVE, 32'hC0A8_0001, 32'd112);
  endtask

  task automatic test_table_full();
    logic [31:0] addr;
    for (int i = 0; i < ENTRIES; i++) begin
      addr = (i == 0) ? 32'h0 : (i == ENTRIES - 1) ? 32'hFFFF_FFFF : $urandom;
      send_msg(gmt_pkg::OP_JOIN, addr, 32'd1000);
    end
    send_msg(gmt_pkg::OP_JOIN, 32'h0A00_0001, 32'd1000);
    // dropped join, then every entry ages out in the same sweep
    send_msg(gmt_pkg::OP_JOIN, 32'h0A00_0002, 32'd1061);
  endtask

  task automatic test_time_wrap();
    send_msg(gmt_pkg::OP_JOIN, 32'hE000_0001, 32'hFFFF_FFF0);
    send_msg(gmt_pkg::OP_JOIN, 32'hE000_0002, 32'h0000_002C);
    send_msg(gmt_pkg::OP_JOIN, 32'hE000_0003, 32'h0000_002D);
  endtask

  task automatic test_timeout_extremes();
    write_timeout(32'hA5A5_0000);
    send_msg(gmt_pkg::OP_JOIN, 32'h1111_1111, 32'd5);
    send_msg(gmt_pkg::OP_JOIN, 32'h2222_2222, 32'd5);
    send_msg(gmt_pkg::OP_JOIN, 32'h2222_2222, 32'd6);
    write_timeout(32'h0000_FFFF);
    send_msg(gmt_pkg::OP_JOIN, 32'h3333_3333, 32'h8000_0000);
    send_msg(gmt_pkg::OP_JOIN, 32'h4444_4444, 32'h8000_FFFF);
    send_msg(gmt_pkg::OP_JOIN, 32'h4444_4444, 32'h8001_0000);
    send_msg(gmt_pkg::OP_LEAVE, 32'h4444_4444, 32'h8001_0000);
  endtask

  task automatic run_aging_phase(input logic [15:0] tmo, input int count);
    logic [31:0] wr;
    logic [31:0] now;
    logic [31:0] step;
    logic [31:0] addr;
    logic op;
    int sent;
    int burst;
    int r;
    wr = $urandom;
    wr[15:0] = tmo;
    write_timeout(wr);
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    now = $urandom;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst && sent < count; b++) begin
        r = $urandom_range(0, 99);
        if (r < 70) step = $urandom_range(0, int'(tmo) / 8 + 1);
        else if (r < 95) step = $urandom_range(0, int'(tmo) + int'(tmo) / 2 + 2);
        else step = $urandom;
        now = now + step;
        r = $urandom_range(0, 99);
        if (r < 60) begin
          op = gmt_pkg::OP_JOIN;
          addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (r < 90) begin
          op = gmt_pkg::OP_LEAVE;
          addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          op = 1'($urandom);
          addr = $urandom;
        end
        send_msg(op, addr, now);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 40));
    end
  endtask

  task automatic test_random_aging();
    run_aging_phase(16'd0, 24);
    run_aging_phase(16'hFFFF, 24);
    run_aging_phase(16'($urandom_range(1, 30)), 24);
    run_aging_phase(16'($urandom_range(31, 300)), 24);
    run_aging_phase(16'($urandom_range(0, 65535)), 24);
  endtask

  // result checker
  always @(posedge clk) begin
    member_event_t exp_ev;
    if (!rst && result_valid) begin
      if (expected_events.size() == 0) begin
        $error("unexpected beat: kind %0d address %0h", event_kind, event_address);
        fail_count++;
      end else begin
        exp_ev = expected_events.pop_front();
        if (event_kind !== exp_ev.kind) begin
          $error("event_kind: expected %0d actual %0d", exp_ev.kind, event_kind);
          fail_count++;
        end
        if (event_address !== exp_ev.addr) begin
          $error("event_address: expected %0h actual %0h", exp_ev.addr, event_address);
          fail_count++;
        end
        if (last_event !== exp_ev.last) begin
          $error("last_event: expected %0d actual %0d", exp_ev.last, last_event);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_addr[i] = '0;
      tbl_active[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_join_leave();
    test_table_full();
    test_time_wrap();
    test_timeout_extremes();
    test_random_aging();
    wait_idle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
